FILE: src/ordq_pkg.sv
package ordq_pkg;

	typedef enum logic [1:0] {
		REQ_INS_FRONT = 2'd0,
		REQ_INS_REAR  = 2'd1,
		REQ_REMOVE    = 2'd2,
		REQ_NONE      = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_DUP   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_CHECK,
		S_COMMIT,
		S_FETCH,
		S_LOAD,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic    accept;
		logic    scan_step;
		logic    commit;
		logic    fetch;
		logic    load_front;
		logic    emit;
		logic    set_status;
		status_t status;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic full;
		logic empty;
		logic last_one;
		logic scan_last;
		logic dup_any;
		logic out_free;
	} sts_t;

	localparam logic [4:0] CAPACITY_RESET = 5'd16;
	localparam int         CAPACITY_W     = 5;
	localparam int         VALUE_W        = 32;
	localparam int         REQ_W          = 2;
	localparam int         COUNT_OUT_W    = 5;

endpackage

FILE: src/ordq_ctrl.sv
module ordq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ordq_pkg::sts_t sts,
	output ordq_pkg::cmd_t cmd
);

	ordq_pkg::state_t state_q;
	ordq_pkg::state_t state_next;
	logic             is_insert;

	assign is_insert = (sts.req == ordq_pkg::REQ_INS_FRONT) ||
		(sts.req == ordq_pkg::REQ_INS_REAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ordq_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ordq_pkg::S_IDLE: begin
				if (in_valid) begin
					state_next = ordq_pkg::S_DECIDE;
				end
			end
			ordq_pkg::S_DECIDE: begin
				if (is_insert) begin
					if (sts.full) begin
						state_next = ordq_pkg::S_EMIT;
					end else if (sts.empty) begin
						state_next = ordq_pkg::S_COMMIT;
					end else begin
						state_next = ordq_pkg::S_SCAN;
					end
				end else if (sts.req == ordq_pkg::REQ_REMOVE) begin
					state_next = sts.empty ? ordq_pkg::S_EMIT : ordq_pkg::S_COMMIT;
				end else begin
					state_next = ordq_pkg::S_EMIT;
				end
			end
			ordq_pkg::S_SCAN: begin
				if (sts.scan_last) begin
					state_next = ordq_pkg::S_CHECK;
				end
			end
			ordq_pkg::S_CHECK: begin
				state_next = sts.dup_any ? ordq_pkg::S_EMIT : ordq_pkg::S_COMMIT;
			end
			ordq_pkg::S_COMMIT: begin
				// a remove that leaves entries must fetch the new front
				if (sts.req == ordq_pkg::REQ_REMOVE && !sts.last_one) begin
					state_next = ordq_pkg::S_FETCH;
				end else begin
					state_next = ordq_pkg::S_EMIT;
				end
			end
			ordq_pkg::S_FETCH: begin
				state_next = ordq_pkg::S_LOAD;
			end
			ordq_pkg::S_LOAD: begin
				state_next = ordq_pkg::S_EMIT;
			end
			ordq_pkg::S_EMIT: begin
				if (sts.out_free) begin
					state_next = ordq_pkg::S_IDLE;
				end
			end
			default: begin
				state_next = ordq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ordq_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ordq_pkg::S_DECIDE: begin
				if (is_insert && sts.full) begin
					cmd.set_status = 1'b1;
					cmd.status     = ordq_pkg::ST_FULL;
				end else if (sts.req == ordq_pkg::REQ_REMOVE && sts.empty) begin
					cmd.set_status = 1'b1;
					cmd.status     = ordq_pkg::ST_EMPTY;
				end
			end
			ordq_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ordq_pkg::S_CHECK: begin
				if (sts.dup_any) begin
					cmd.set_status = 1'b1;
					cmd.status     = ordq_pkg::ST_DUP;
				end
			end
			ordq_pkg::S_COMMIT: begin
				cmd.commit = 1'b1;
			end
			ordq_pkg::S_FETCH: begin
				cmd.fetch = 1'b1;
			end
			ordq_pkg::S_LOAD: begin
				cmd.load_front = 1'b1;
			end
			ordq_pkg::S_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == ordq_pkg::S_IDLE)
		else $error("emit did not return to idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ordq_pkg::S_SCAN) |-> cmd.scan_step && !in_ready)
		else $error("scan state without scan step");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(cmd.set_status))
		else $error("status changed during commit");

endmodule

FILE: src/ordq_dp.sv
module ordq_dp #(
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ordq_pkg::cmd_t                   cmd,
	output ordq_pkg::sts_t                   sts,
	input  logic [ordq_pkg::REQ_W-1:0]       in_req,
	input  logic [ordq_pkg::VALUE_W-1:0]     in_value,
	input  logic [ordq_pkg::CAPACITY_W-1:0]  capacity,
	output logic                             out_valid,
	input  logic                             out_ready,
	output ordq_pkg::status_t                out_status,
	output logic [ordq_pkg::VALUE_W-1:0]     out_removed,
	output logic [ordq_pkg::VALUE_W-1:0]     out_front,
	output logic [ordq_pkg::VALUE_W-1:0]     out_rear,
	output logic [ordq_pkg::COUNT_OUT_W-1:0] out_count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > ordq_pkg::CAPACITY_W) ? CW : ordq_pkg::CAPACITY_W;

	logic [ordq_pkg::VALUE_W-1:0] mem [DEPTH];

	logic [AW-1:0]                head_q;
	logic [CW-1:0]                count_q;
	logic [AW-1:0]                scan_idx_q;
	logic [ordq_pkg::VALUE_W-1:0] front_q;
	logic [ordq_pkg::VALUE_W-1:0] rear_q;
	logic [ordq_pkg::VALUE_W-1:0] val_q;
	logic [ordq_pkg::VALUE_W-1:0] rdata_q;
	logic [ordq_pkg::VALUE_W-1:0] removed_q;
	ordq_pkg::req_t               req_q;
	ordq_pkg::status_t            status_q;
	logic                         dup_q;
	logic                         cmp_vld_s1;

	logic                             out_valid_q;
	ordq_pkg::status_t                out_status_q;
	logic [ordq_pkg::VALUE_W-1:0]     out_removed_q;
	logic [ordq_pkg::VALUE_W-1:0]     out_front_q;
	logic [ordq_pkg::VALUE_W-1:0]     out_rear_q;
	logic [ordq_pkg::COUNT_OUT_W-1:0] out_count_q;

	logic [AW:0]     scan_sum;
	logic [AW-1:0]   scan_slot;
	logic [AW:0]     rear_sum;
	logic [AW-1:0]   rear_slot;
	logic [AW-1:0]   head_dec;
	logic [AW-1:0]   head_inc;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	logic            wr_en;
	logic            is_insert;
	logic            empty;
	logic            match;
	logic [LW-1:0]   cap_ext;
	logic [LW-1:0]   limit;
	logic [CW+4:0]   count_wide;

	assign is_insert = (req_q == ordq_pkg::REQ_INS_FRONT) || (req_q == ordq_pkg::REQ_INS_REAR);
	assign empty     = (count_q == '0);

	// offsets stay below DEPTH, so one conditional subtract wraps them
	assign scan_sum  = {1'b0, head_q} + {1'b0, scan_idx_q};
	assign scan_slot = (scan_sum >= (AW+1)'(DEPTH)) ?
		AW'(scan_sum - (AW+1)'(DEPTH)) : scan_sum[AW-1:0];
	assign rear_sum  = {1'b0, head_q} + (AW+1)'(count_q);
	assign rear_slot = (rear_sum >= (AW+1)'(DEPTH)) ?
		AW'(rear_sum - (AW+1)'(DEPTH)) : rear_sum[AW-1:0];
	assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	assign rd_addr = cmd.fetch ? head_q : scan_slot;
	assign wr_en   = cmd.commit && is_insert;
	assign wr_addr = (req_q == ordq_pkg::REQ_INS_FRONT) ? head_dec : rear_slot;

	assign cap_ext = LW'(capacity);
	assign limit   = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
	assign match   = cmp_vld_s1 && (rdata_q == val_q);

	assign count_wide = {5'b0, count_q};

	assign sts.req       = req_q;
	assign sts.full      = (LW'(count_q) >= limit);
	assign sts.empty     = empty;
	assign sts.last_one  = (count_q == CW'(1));
	assign sts.scan_last = ((CW'(scan_idx_q) + CW'(1)) == count_q);
	assign sts.dup_any   = dup_q || match;
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= val_q;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			cmp_vld_s1  <= 1'b0;
			dup_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_step;
			if (cmd.accept) begin
				dup_q <= 1'b0;
			end else if (match) begin
				dup_q <= 1'b1;
			end
			if (cmd.commit) begin
				if (is_insert) begin
					count_q <= count_q + CW'(1);
					if (req_q == ordq_pkg::REQ_INS_FRONT) begin
						head_q <= head_dec;
					end
				end else begin
					count_q <= count_q - CW'(1);
					head_q  <= head_inc;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q      <= ordq_pkg::req_t'(in_req);
			val_q      <= in_value;
			status_q   <= ordq_pkg::ST_OK;
			removed_q  <= '0;
			scan_idx_q <= '0;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status;
			end
			if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + AW'(1);
			end
		end
		if (cmd.commit) begin
			if (req_q == ordq_pkg::REQ_INS_FRONT) begin
				front_q <= val_q;
				if (empty) begin
					rear_q <= val_q;
				end
			end else if (req_q == ordq_pkg::REQ_INS_REAR) begin
				rear_q <= val_q;
				if (empty) begin
					front_q <= val_q;
				end
			end else begin
				removed_q <= front_q;
			end
		end
		if (cmd.load_front) begin
			front_q <= rdata_q;
		end
		if (cmd.emit) begin
			out_status_q  <= status_q;
			out_removed_q <= removed_q;
			out_front_q   <= empty ? '0 : front_q;
			out_rear_q    <= empty ? '0 : rear_q;
			out_count_q   <= count_wide[4:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_removed = out_removed_q;
	assign out_front   = out_front_q;
	assign out_rear    = out_rear_q;
	assign out_count   = out_count_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_insert) |-> !sts.full)
		else $error("insert committed into a full deque");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && req_q == ordq_pkg::REQ_REMOVE) |=> count_q == $past(count_q) - CW'(1))
		else $error("remove did not drop the count");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

endmodule

FILE: src/output_restricted_deque_unique.sv
// Bounded deque of signed 32-bit values: insert at front or rear, remove from
// the front only. Inserts that would exceed the capacity, or that repeat a
// stored value, are refused.
// Input beat (s_*): s_tuser = request (0 insert front, 1 insert rear,
// 2 remove, 3 no-op), s_tdata = value. One result beat (m_*) per input beat:
// m_tuser = status, m_tdata = removed, front, rear values and entry count.
// Capacity register at APB address 0 (reset 16, clamped to DEPTH).
// From accept, the request passes the decide state; a no-op, a full insert or a
// remove from empty goes on to emit. An insert into a non-empty deque first
// scans the stored entries and checks for a duplicate, which goes to emit; other
// inserts and removes pass commit, and a remove that leaves entries then fetches
// and loads the new front before emit. The next beat is taken in the cycle after
// the emit. The duplicate check reads the stored entries one per cycle through
// the single read port of the entry memory, which sets the insert rate.
// Reset empties the deque at once (head and count cleared); no memory sweep.
// The result sits in an output register; a stalled receiver holds it there.
// The block still takes one new beat and works it through, then holds in the
// emit state, taking no further beat until the register is free.
module output_restricted_deque_unique #(
	parameter int DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,  // [31:0] value
	input  logic [1:0]   s_tuser,  // [1:0] req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] removed_value, [63:32] front_value, [95:64] rear_value,
	// [100:96] entry_count, [103:101] zero
	output logic [103:0] m_tdata,
	output logic [1:0]   m_tuser,  // [1:0] status
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [ordq_pkg::CAPACITY_W-1:0]  capacity_q;
	ordq_pkg::cmd_t                   cmd;
	ordq_pkg::sts_t                   sts;
	ordq_pkg::status_t                out_status;
	logic [ordq_pkg::VALUE_W-1:0]     out_removed;
	logic [ordq_pkg::VALUE_W-1:0]     out_front;
	logic [ordq_pkg::VALUE_W-1:0]     out_rear;
	logic [ordq_pkg::COUNT_OUT_W-1:0] out_count;
	logic                             cap_sel;

	assign pready  = 1'b1;
	assign cap_sel = (paddr[2] == 1'b0);
	assign prdata  = cap_sel ? {27'b0, capacity_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= ordq_pkg::CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready && cap_sel) begin
			capacity_q <= pwdata[4:0];
		end
	end

	ordq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ordq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_req      (s_tuser),
		.in_value    (s_tdata),
		.capacity    (capacity_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (out_status),
		.out_removed (out_removed),
		.out_front   (out_front),
		.out_rear    (out_rear),
		.out_count   (out_count)
	);

	assign m_tuser = out_status;
	assign m_tdata = {3'b0, out_count, out_rear, out_front, out_removed};

endmodule
